[hw/rtl/ray_box_slab_test_top_assert.svh]
// Assertion macros for the ray/box slab test block.
`ifndef RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_TOP_ASSERT_SVH

// Antecedent in one cycle implies consequent in the next, outside reset.
`define RBST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbst assertion failed");

// Antecedent implies consequent in the same cycle, outside reset.
`define RBST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbst assertion failed");

`endif

[hw/rtl/rbst_pkg.sv]
// Shared types and constants for the ray/box slab test block.
`timescale 1ns / 1ps
package rbst_pkg;

    localparam int AXES     = 3;
    localparam int COORD_W  = 32;
    localparam int NUM_W    = COORD_W + 1;
    localparam int PROD_W   = 64;
    localparam int PAIRS    = 6;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_B_Z = 3'd5;

    // Ordered axis pairs (i, j), i != j: entry of i against exit of j
    localparam logic [1:0] PAIR_I [PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic [1:0] PAIR_J [PAIRS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

    typedef struct packed {
        logic                    bounded;
        logic                    ok;
        logic signed [NUM_W-1:0] nmin;
        logic signed [NUM_W-1:0] nmax;
        logic [COORD_W-1:0]      den;
    } slab_t;

endpackage

[hw/rtl/rbst_slab.sv]
// Per-axis slab setup: bounds ordering, entry/exit numerators, denominator.
`timescale 1ns / 1ps
module rbst_slab
(
    input  logic signed [rbst_pkg::COORD_W-1:0] corner_a,
    input  logic signed [rbst_pkg::COORD_W-1:0] corner_b,
    input  logic signed [rbst_pkg::COORD_W-1:0] origin,
    input  logic signed [rbst_pkg::COORD_W-1:0] dir,
    output rbst_pkg::slab_t                     slab
);

    logic signed [rbst_pkg::NUM_W-1:0] lo;
    logic signed [rbst_pkg::NUM_W-1:0] hi;
    logic signed [rbst_pkg::NUM_W-1:0] org;

    always_comb
    begin
        lo  = (corner_a < corner_b) ? {corner_a[31], corner_a} : {corner_b[31], corner_b};
        hi  = (corner_a < corner_b) ? {corner_b[31], corner_b} : {corner_a[31], corner_a};
        org = {origin[31], origin};
        slab = '0;
        if (dir == '0)
        begin
            slab.bounded = 1'b0;
            slab.den     = 32'd1;
            slab.ok      = (org >= lo) && (org <= hi);
        end
        else if (!dir[31])
        begin
            slab.bounded = 1'b1;
            slab.ok      = 1'b1;
            slab.nmin    = lo - org;
            slab.nmax    = hi - org;
            slab.den     = dir;
        end
        else
        begin
            slab.bounded = 1'b1;
            slab.ok      = 1'b1;
            slab.nmin    = org - hi;
            slab.nmax    = org - lo;
            slab.den     = (~dir) + 32'd1;   // |dir|, 2^31 fits unsigned
        end
    end

endmodule

[hw/rtl/rbst_pair.sv]
// Cross products for one ordered axis pair, registered.
`timescale 1ns / 1ps
module rbst_pair
(
    input  logic                                clk,
    input  logic                                en,
    input  rbst_pkg::slab_t                     slab_i,
    input  rbst_pkg::slab_t                     slab_j,
    output logic signed [rbst_pkg::PROD_W-1:0]  lhs_reg,
    output logic signed [rbst_pkg::PROD_W-1:0]  rhs_reg
);

    logic signed [2*rbst_pkg::NUM_W-1:0] lhs_full;
    logic signed [2*rbst_pkg::NUM_W-1:0] rhs_full;

    // nmin_i * den_j  vs  nmax_j * den_i; magnitudes stay below 2^63
    assign lhs_full = slab_i.nmin * $signed({1'b0, slab_j.den});
    assign rhs_full = slab_j.nmax * $signed({1'b0, slab_i.den});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs_reg <= $signed(lhs_full[rbst_pkg::PROD_W-1:0]);
            rhs_reg <= $signed(rhs_full[rbst_pkg::PROD_W-1:0]);
        end
    end

endmodule

[hw/rtl/ray_box_slab_test_top.sv]
// Top level of the ray/axis-aligned box slab test pipeline.
// An input word passes the slab, product and hit registers to its result word.
// Throughput: one ray per cycle; the three stages (slab setup, cross products,
//   compare and reduce) move together and hold as a whole while the output stalls.
// Reset: rst_n is asynchronous, active low; clears the valid bits and the six
//   corner registers to zero. Payload registers are not reset.
`timescale 1ns / 1ps
module ray_box_slab_test_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [rbst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbst_pkg::COORD_W-1:0]         cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rbst_pkg::COORD_W-1:0]  origin_x,
    input  logic signed [rbst_pkg::COORD_W-1:0]  origin_y,
    input  logic signed [rbst_pkg::COORD_W-1:0]  origin_z,
    input  logic signed [rbst_pkg::COORD_W-1:0]  dir_x,
    input  logic signed [rbst_pkg::COORD_W-1:0]  dir_y,
    input  logic signed [rbst_pkg::COORD_W-1:0]  dir_z,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 hit
);

`include "ray_box_slab_test_top_assert.svh"

    localparam int AXES  = rbst_pkg::AXES;
    localparam int PAIRS = rbst_pkg::PAIRS;

    // Box corners, one per axis
    logic signed [rbst_pkg::COORD_W-1:0] corner_a_reg [AXES];
    logic signed [rbst_pkg::COORD_W-1:0] corner_b_reg [AXES];

    // Whole pipeline advances unless a finished word waits on a stalled output.
    logic advance;
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    // ---------------- stage 1: slab setup ----------------
    logic signed [rbst_pkg::COORD_W-1:0] org_in [AXES];
    logic signed [rbst_pkg::COORD_W-1:0] dir_in [AXES];
    rbst_pkg::slab_t                     slab_next [AXES];
    rbst_pkg::slab_t                     slab_reg  [AXES];
    logic                                v1_reg;

    assign org_in[0] = origin_x;
    assign org_in[1] = origin_y;
    assign org_in[2] = origin_z;
    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;

    for (genvar a = 0; a < AXES; a++)
    begin : g_axis
        rbst_slab u_slab
        (
            .corner_a (corner_a_reg[a]),
            .corner_b (corner_b_reg[a]),
            .origin   (org_in[a]),
            .dir      (dir_in[a]),
            .slab     (slab_next[a])
        );

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                slab_reg[a] <= slab_next[a];
            end
        end
    end

    // ---------------- stage 2: cross products ----------------
    logic signed [rbst_pkg::PROD_W-1:0] lhs_reg [PAIRS];
    logic signed [rbst_pkg::PROD_W-1:0] rhs_reg [PAIRS];
    logic [AXES-1:0]                    bnd2_reg;
    logic                               ok2_reg;
    logic                               v2_reg;

    for (genvar k = 0; k < PAIRS; k++)
    begin : g_pair
        rbst_pair u_pair
        (
            .clk     (clk),
            .en      (advance),
            .slab_i  (slab_reg[rbst_pkg::PAIR_I[k]]),
            .slab_j  (slab_reg[rbst_pkg::PAIR_J[k]]),
            .lhs_reg (lhs_reg[k]),
            .rhs_reg (rhs_reg[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ok2_reg <= slab_reg[0].ok && slab_reg[1].ok && slab_reg[2].ok;
            for (int a = 0; a < AXES; a++)
            begin
                bnd2_reg[a] <= slab_reg[a].bounded;
            end
        end
    end

    // ---------------- stage 3: compare and reduce ----------------
    // Miss if !ok2_reg or a bounded entry is strictly after another bounded exit.
    logic [PAIRS-1:0] late;
    logic             hit_next;

    always_comb
    begin
        for (int k = 0; k < PAIRS; k++)
        begin
            late[k] = bnd2_reg[rbst_pkg::PAIR_I[k]] && bnd2_reg[rbst_pkg::PAIR_J[k]]
                      && (lhs_reg[k] > rhs_reg[k]);
        end
        hit_next = ok2_reg && (late == '0);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit <= hit_next;
        end
    end

    // ---------------- control: valid bits and corner registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                corner_a_reg[a] <= '0;
                corner_b_reg[a] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                v1_reg    <= in_valid;
                v2_reg    <= v1_reg;
                out_valid <= v2_reg;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rbst_pkg::REG_A_X: corner_a_reg[0] <= cfg_data;
                    rbst_pkg::REG_A_Y: corner_a_reg[1] <= cfg_data;
                    rbst_pkg::REG_A_Z: corner_a_reg[2] <= cfg_data;
                    rbst_pkg::REG_B_X: corner_b_reg[0] <= cfg_data;
                    rbst_pkg::REG_B_Y: corner_b_reg[1] <= cfg_data;
                    rbst_pkg::REG_B_Z: corner_b_reg[2] <= cfg_data;
                    default: ;   // indexes past the list are ignored
                endcase
            end
        end
    end

    // ---------------- assertions ----------------
    `RBST_ASSERT_NEXT(a_v1_to_v2, v1_reg && advance, v2_reg)
    `RBST_ASSERT_NEXT(a_v2_to_out, v2_reg && advance, out_valid)
    `RBST_ASSERT_NEXT(a_bad_slab_miss, v2_reg && advance && !ok2_reg, !hit)
    `RBST_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid)

endmodule
